@@ src/perpendicular_basis_unit_macros.svh @@
`ifndef PERPENDICULAR_BASIS_UNIT_MACROS_SVH
`define PERPENDICULAR_BASIS_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PBU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define PBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pbu_pkg.sv @@
package pbu_pkg;

   localparam int IN_W        = 24;
   localparam int SQ_W        = 47;
   localparam int SUM_W       = 48;
   localparam int HALF_W      = 24;
   localparam int WIDE_W      = 96;
   localparam int REM_W       = WIDE_W + 1;
   localparam int Q_W         = 34;
   localparam int ROOT_W      = Q_W / 2;
   localparam int RAD_W       = ROOT_W + 4;
   localparam int MAG_W       = 17;
   localparam int OUT_W       = 18;
   localparam int NUM_UNITS   = 5;
   localparam int NUM_PRODS   = 3;
   localparam int PP_NUM      = 4;
   localparam int DIV_STAGES  = Q_W;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int FRONT_LAT   = 4;
   localparam int UNIT_LAT    = DIV_STAGES + SQRT_STAGES + 2;

   localparam logic [MAG_W-1:0] ONE_Q16 = MAG_W'(65536);

   // Magnitude units
   localparam int U_NORM   = 0;
   localparam int U_PROD_A = 1;
   localparam int U_PROD_B = 2;
   localparam int U_Z      = 3;
   localparam int U_W      = 4;

   // Wide products
   localparam int P_XY = 0;
   localparam int P_ZV = 1;
   localparam int P_ST = 2;

   // Partial products of a split multiply
   localparam int PP_LL = 0;
   localparam int PP_LH = 1;
   localparam int PP_HL = 2;
   localparam int PP_HH = 3;

   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [MAG_W-1:0]  mag_type;

   typedef struct packed {
      logic nonzero;
      logic br_a;
      logic nx;
      logic ny;
      logic nz;
   } side_type;

   function automatic logic [OUT_W-1:0] enc(input logic neg, input mag_type mag);
      logic [OUT_W-1:0] m;
      m = OUT_W'(mag);
      return neg ? OUT_W'(-m) : m;
   endfunction

endpackage

@@ src/pbu_front.sv @@
module pbu_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic signed [pbu_pkg::IN_W-1:0]       vec_x,
   input  logic signed [pbu_pkg::IN_W-1:0]       vec_y,
   input  logic signed [pbu_pkg::IN_W-1:0]       vec_z,
   output logic                                  out_valid,
   output pbu_pkg::side_type                     out_side,
   output pbu_pkg::wide_type                     num_o [pbu_pkg::NUM_UNITS],
   output pbu_pkg::wide_type                     den_o [pbu_pkg::NUM_UNITS]
);

   logic [pbu_pkg::IN_W-1:0]   ax, ay, az;
   logic [2*pbu_pkg::IN_W-1:0] x2_full, y2_full, z2_full;
   pbu_pkg::side_type          side_in;

   logic                       valid_ff [pbu_pkg::FRONT_LAT];
   pbu_pkg::side_type          side_ff  [pbu_pkg::FRONT_LAT];

   // stage 1
   logic [pbu_pkg::SQ_W-1:0]   x2_ff, y2_ff, z2_ff;
   // stage 2
   logic [pbu_pkg::SUM_W-1:0]  s2_in, t2_in, s2_ff, t2_ff;
   logic [pbu_pkg::SQ_W-1:0]   v2_in, w2_in;
   logic [pbu_pkg::SQ_W-1:0]   x2b_ff, y2b_ff, z2b_ff, v2_ff, w2_ff;
   // stage 3
   logic [pbu_pkg::SUM_W-1:0]  opa [pbu_pkg::NUM_PRODS];
   logic [pbu_pkg::SUM_W-1:0]  opb [pbu_pkg::NUM_PRODS];
   logic [pbu_pkg::SUM_W-1:0]  pp_in [pbu_pkg::NUM_PRODS][pbu_pkg::PP_NUM];
   logic [pbu_pkg::SUM_W-1:0]  pp_ff [pbu_pkg::NUM_PRODS][pbu_pkg::PP_NUM];
   logic [pbu_pkg::SUM_W-1:0]  s3_ff, t3_ff;
   logic [pbu_pkg::SQ_W-1:0]   z3_ff, w3_ff;
   // stage 4
   pbu_pkg::wide_type          prod [pbu_pkg::NUM_PRODS];
   pbu_pkg::wide_type          num_in [pbu_pkg::NUM_UNITS];
   pbu_pkg::wide_type          den_in [pbu_pkg::NUM_UNITS];
   pbu_pkg::wide_type          num_ff [pbu_pkg::NUM_UNITS];
   pbu_pkg::wide_type          den_ff [pbu_pkg::NUM_UNITS];

   always_comb begin
      ax = vec_x[pbu_pkg::IN_W-1] ? pbu_pkg::IN_W'(-vec_x) : pbu_pkg::IN_W'(vec_x);
      ay = vec_y[pbu_pkg::IN_W-1] ? pbu_pkg::IN_W'(-vec_y) : pbu_pkg::IN_W'(vec_y);
      az = vec_z[pbu_pkg::IN_W-1] ? pbu_pkg::IN_W'(-vec_z) : pbu_pkg::IN_W'(vec_z);
      x2_full = ax * ax;
      y2_full = ay * ay;
      z2_full = az * az;
      side_in.nonzero = (ax != '0) || (ay != '0) || (az != '0);
      side_in.br_a    = ax < ay;
      side_in.nx      = vec_x[pbu_pkg::IN_W-1];
      side_in.ny      = vec_y[pbu_pkg::IN_W-1];
      side_in.nz      = vec_z[pbu_pkg::IN_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbu_pkg::FRONT_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < pbu_pkg::FRONT_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < pbu_pkg::FRONT_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // stage 1: squares
   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff <= x2_full[pbu_pkg::SQ_W-1:0];
         y2_ff <= y2_full[pbu_pkg::SQ_W-1:0];
         z2_ff <= z2_full[pbu_pkg::SQ_W-1:0];
      end
   end

   // stage 2: length squared and branch operand selection
   always_comb begin
      s2_in = pbu_pkg::SUM_W'(x2_ff) + pbu_pkg::SUM_W'(y2_ff) + pbu_pkg::SUM_W'(z2_ff);
      if (side_ff[0].br_a) begin
         t2_in = pbu_pkg::SUM_W'(y2_ff) + pbu_pkg::SUM_W'(z2_ff);
         v2_in = x2_ff;
         w2_in = y2_ff;
      end else begin
         t2_in = pbu_pkg::SUM_W'(x2_ff) + pbu_pkg::SUM_W'(z2_ff);
         v2_in = y2_ff;
         w2_in = x2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff  <= s2_in;
         t2_ff  <= t2_in;
         x2b_ff <= x2_ff;
         y2b_ff <= y2_ff;
         z2b_ff <= z2_ff;
         v2_ff  <= v2_in;
         w2_ff  <= w2_in;
      end
   end

   // stage 3: split each wide product into four half-width partials
   always_comb begin
      opa[pbu_pkg::P_XY] = pbu_pkg::SUM_W'(x2b_ff);
      opb[pbu_pkg::P_XY] = pbu_pkg::SUM_W'(y2b_ff);
      opa[pbu_pkg::P_ZV] = pbu_pkg::SUM_W'(z2b_ff);
      opb[pbu_pkg::P_ZV] = pbu_pkg::SUM_W'(v2_ff);
      opa[pbu_pkg::P_ST] = s2_ff;
      opb[pbu_pkg::P_ST] = t2_ff;
      for (int p = 0; p < pbu_pkg::NUM_PRODS; p++) begin
         pp_in[p][pbu_pkg::PP_LL] = opa[p][pbu_pkg::HALF_W-1:0]
                                  * opb[p][pbu_pkg::HALF_W-1:0];
         pp_in[p][pbu_pkg::PP_LH] = opa[p][pbu_pkg::HALF_W-1:0]
                                  * opb[p][pbu_pkg::SUM_W-1:pbu_pkg::HALF_W];
         pp_in[p][pbu_pkg::PP_HL] = opa[p][pbu_pkg::SUM_W-1:pbu_pkg::HALF_W]
                                  * opb[p][pbu_pkg::HALF_W-1:0];
         pp_in[p][pbu_pkg::PP_HH] = opa[p][pbu_pkg::SUM_W-1:pbu_pkg::HALF_W]
                                  * opb[p][pbu_pkg::SUM_W-1:pbu_pkg::HALF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff <= pp_in;
         s3_ff <= s2_ff;
         t3_ff <= t2_ff;
         z3_ff <= z2b_ff;
         w3_ff <= w2_ff;
      end
   end

   // stage 4: combine partials, route numerator and denominator per unit
   always_comb begin
      for (int p = 0; p < pbu_pkg::NUM_PRODS; p++) begin
         prod[p] = (pbu_pkg::WIDE_W'(pp_ff[p][pbu_pkg::PP_HH]) << (2 * pbu_pkg::HALF_W))
                 + ((pbu_pkg::WIDE_W'(pp_ff[p][pbu_pkg::PP_LH])
                   + pbu_pkg::WIDE_W'(pp_ff[p][pbu_pkg::PP_HL])) << pbu_pkg::HALF_W)
                 + pbu_pkg::WIDE_W'(pp_ff[p][pbu_pkg::PP_LL]);
      end
      num_in[pbu_pkg::U_NORM]   = pbu_pkg::WIDE_W'(t3_ff);
      den_in[pbu_pkg::U_NORM]   = pbu_pkg::WIDE_W'(s3_ff);
      num_in[pbu_pkg::U_PROD_A] = prod[pbu_pkg::P_XY];
      den_in[pbu_pkg::U_PROD_A] = prod[pbu_pkg::P_ST];
      num_in[pbu_pkg::U_PROD_B] = prod[pbu_pkg::P_ZV];
      den_in[pbu_pkg::U_PROD_B] = prod[pbu_pkg::P_ST];
      num_in[pbu_pkg::U_Z]      = pbu_pkg::WIDE_W'(z3_ff);
      den_in[pbu_pkg::U_Z]      = pbu_pkg::WIDE_W'(t3_ff);
      num_in[pbu_pkg::U_W]      = pbu_pkg::WIDE_W'(w3_ff);
      den_in[pbu_pkg::U_W]      = pbu_pkg::WIDE_W'(t3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = valid_ff[pbu_pkg::FRONT_LAT-1];
   assign out_side  = side_ff[pbu_pkg::FRONT_LAT-1];
   assign num_o     = num_ff;
   assign den_o     = den_ff;

endmodule

@@ src/pbu_unit_mag.sv @@
module pbu_unit_mag (
   input  logic              clock,
   input  logic              adv,
   input  pbu_pkg::wide_type num_i,
   input  pbu_pkg::wide_type den_i,
   output pbu_pkg::mag_type  mag_o
);

   logic [pbu_pkg::REM_W-1:0]  div_rem_ff [pbu_pkg::DIV_STAGES+1];
   pbu_pkg::wide_type          div_den_ff [pbu_pkg::DIV_STAGES+1];
   logic [pbu_pkg::Q_W-1:0]    div_q_ff   [pbu_pkg::DIV_STAGES+1];
   logic                       div_ge_ff  [pbu_pkg::DIV_STAGES+1];

   logic [pbu_pkg::Q_W-1:0]    sq_rad_ff  [pbu_pkg::SQRT_STAGES];
   logic [pbu_pkg::RAD_W-1:0]  sq_r_ff    [pbu_pkg::SQRT_STAGES];
   logic [pbu_pkg::ROOT_W-1:0] sq_root_ff [pbu_pkg::SQRT_STAGES];
   logic                       sq_ge_ff   [pbu_pkg::SQRT_STAGES];

   logic [pbu_pkg::ROOT_W:0]   rnd;
   pbu_pkg::mag_type           mag_in, mag_ff;

   // ratio of one or more saturates to unity
   always_ff @(posedge clock) begin
      if (adv) begin
         div_rem_ff[0] <= pbu_pkg::REM_W'(num_i);
         div_den_ff[0] <= den_i;
         div_q_ff[0]   <= '0;
         div_ge_ff[0]  <= num_i >= den_i;
      end
   end

   // restoring fraction divider, one quotient bit per stage
   for (genvar k = 1; k <= pbu_pkg::DIV_STAGES; k++) begin : g_div
      logic [pbu_pkg::REM_W-1:0] rem2, dext;
      logic                      take;
      always_comb begin
         rem2 = {div_rem_ff[k-1][pbu_pkg::REM_W-2:0], 1'b0};
         dext = pbu_pkg::REM_W'(div_den_ff[k-1]);
         take = rem2 >= dext;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_rem_ff[k] <= take ? (rem2 - dext) : rem2;
            div_den_ff[k] <= div_den_ff[k-1];
            div_q_ff[k]   <= {div_q_ff[k-1][pbu_pkg::Q_W-2:0], take};
            div_ge_ff[k]  <= div_ge_ff[k-1];
         end
      end
   end

   // digit-by-digit square root, two radicand bits per stage
   for (genvar j = 0; j < pbu_pkg::SQRT_STAGES; j++) begin : g_sqrt
      logic [pbu_pkg::Q_W-1:0]    src_rad;
      logic [pbu_pkg::RAD_W-1:0]  src_r, r2, trial;
      logic [pbu_pkg::ROOT_W-1:0] src_root;
      logic                       src_ge, take;
      if (j == 0) begin : g_first
         assign src_rad  = div_q_ff[pbu_pkg::DIV_STAGES];
         assign src_r    = '0;
         assign src_root = '0;
         assign src_ge   = div_ge_ff[pbu_pkg::DIV_STAGES];
      end else begin : g_next
         assign src_rad  = sq_rad_ff[j-1];
         assign src_r    = sq_r_ff[j-1];
         assign src_root = sq_root_ff[j-1];
         assign src_ge   = sq_ge_ff[j-1];
      end
      always_comb begin
         r2    = {src_r[pbu_pkg::RAD_W-3:0], src_rad[pbu_pkg::Q_W-1 -: 2]};
         trial = pbu_pkg::RAD_W'({src_root, 2'b01});
         take  = r2 >= trial;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rad_ff[j]  <= {src_rad[pbu_pkg::Q_W-3:0], 2'b00};
            sq_r_ff[j]    <= take ? (r2 - trial) : r2;
            sq_root_ff[j] <= {src_root[pbu_pkg::ROOT_W-2:0], take};
            sq_ge_ff[j]   <= src_ge;
         end
      end
   end

   // round half up on the extra root bit
   always_comb begin
      rnd    = {1'b0, sq_root_ff[pbu_pkg::SQRT_STAGES-1]} + 1'b1;
      mag_in = sq_ge_ff[pbu_pkg::SQRT_STAGES-1] ? pbu_pkg::ONE_Q16
                                                : pbu_pkg::MAG_W'(rnd[pbu_pkg::ROOT_W:1]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
      end
   end

   assign mag_o = mag_ff;

endmodule

@@ src/perpendicular_basis_unit.sv @@
// An accepted request passes 4 setup stages, a 53-stage magnitude unit per component
// (input register, 34 divide stages, 17 square root stages and a rounding register)
// and then the output register on the way to its response.
// Throughput: one vector per cycle; a stalled response freezes the whole pipeline.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`include "perpendicular_basis_unit_macros.svh"

module perpendicular_basis_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [pbu_pkg::IN_W-1:0]    req_vec_x,
   input  logic signed [pbu_pkg::IN_W-1:0]    req_vec_y,
   input  logic signed [pbu_pkg::IN_W-1:0]    req_vec_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_valid_res,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_b_x,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_b_y,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_b_z,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_c_x,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_c_y,
   output logic signed [pbu_pkg::OUT_W-1:0]   rsp_perp_c_z
);

   logic                     adv;
   logic                     front_valid;
   pbu_pkg::side_type        front_side;
   pbu_pkg::wide_type        num [pbu_pkg::NUM_UNITS];
   pbu_pkg::wide_type        den [pbu_pkg::NUM_UNITS];
   pbu_pkg::mag_type         mag [pbu_pkg::NUM_UNITS];

   logic                     dly_valid_ff [pbu_pkg::UNIT_LAT];
   pbu_pkg::side_type        dly_side_ff  [pbu_pkg::UNIT_LAT];
   pbu_pkg::side_type        sd;

   logic                     rsp_valid_ff;
   logic                     res_in, res_ff;
   logic [pbu_pkg::OUT_W-1:0] bx_in, by_in, bz_in, cx_in, cy_in, cz_in;
   logic [pbu_pkg::OUT_W-1:0] bx_ff, by_ff, bz_ff, cx_ff, cy_ff, cz_ff;

   // advance everything unless a response is held back
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   pbu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_z     (req_vec_z),
      .out_valid (front_valid),
      .out_side  (front_side),
      .num_o     (num),
      .den_o     (den)
   );

   for (genvar u = 0; u < pbu_pkg::NUM_UNITS; u++) begin : g_unit
      pbu_unit_mag u_mag (
         .clock (clock),
         .adv   (adv),
         .num_i (num[u]),
         .den_i (den[u]),
         .mag_o (mag[u])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbu_pkg::UNIT_LAT; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dly_valid_ff[0] <= front_valid;
         for (int i = 1; i < pbu_pkg::UNIT_LAT; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_side_ff[0] <= front_side;
         for (int i = 1; i < pbu_pkg::UNIT_LAT; i++) begin
            dly_side_ff[i] <= dly_side_ff[i-1];
         end
      end
   end

   assign sd = dly_side_ff[pbu_pkg::UNIT_LAT-1];

   // place magnitudes and signs by branch
   always_comb begin
      res_in = sd.nonzero;
      bx_in  = '0;
      by_in  = '0;
      bz_in  = '0;
      cx_in  = '0;
      cy_in  = '0;
      cz_in  = '0;
      if (sd.nonzero) begin
         if (sd.br_a) begin
            bx_in = pbu_pkg::enc(1'b1, mag[pbu_pkg::U_NORM]);
            by_in = pbu_pkg::enc(sd.nx ^ sd.ny, mag[pbu_pkg::U_PROD_A]);
            bz_in = pbu_pkg::enc(sd.nx ^ sd.nz, mag[pbu_pkg::U_PROD_B]);
            cy_in = pbu_pkg::enc(sd.nz, mag[pbu_pkg::U_Z]);
            cz_in = pbu_pkg::enc(!sd.ny, mag[pbu_pkg::U_W]);
         end else begin
            bx_in = pbu_pkg::enc(!sd.nz, mag[pbu_pkg::U_Z]);
            bz_in = pbu_pkg::enc(sd.nx, mag[pbu_pkg::U_W]);
            cx_in = pbu_pkg::enc(sd.nx ^ sd.ny, mag[pbu_pkg::U_PROD_A]);
            cy_in = pbu_pkg::enc(1'b1, mag[pbu_pkg::U_NORM]);
            cz_in = pbu_pkg::enc(sd.ny ^ sd.nz, mag[pbu_pkg::U_PROD_B]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dly_valid_ff[pbu_pkg::UNIT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         bz_ff  <= bz_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = res_ff;
   assign rsp_perp_b_x  = bx_ff;
   assign rsp_perp_b_y  = by_ff;
   assign rsp_perp_b_z  = bz_ff;
   assign rsp_perp_c_x  = cx_ff;
   assign rsp_perp_c_y  = cy_ff;
   assign rsp_perp_c_z  = cz_ff;

   `PBU_ASSERT_NOW(a_zero_clear, clock, reset, rsp_valid && !rsp_valid_res, (rsp_perp_b_x == '0) && (rsp_perp_b_y == '0) && (rsp_perp_b_z == '0) && (rsp_perp_c_x == '0) && (rsp_perp_c_y == '0) && (rsp_perp_c_z == '0), "zero vector gave nonzero basis")
   `PBU_ASSERT_NOW(a_axis_zero, clock, reset, rsp_valid && rsp_valid_res, (rsp_perp_b_y == '0) || (rsp_perp_c_x == '0), "no axis component is zero")
   `PBU_ASSERT_NOW(a_norm_sign, clock, reset, rsp_valid && rsp_valid_res, rsp_perp_b_x[pbu_pkg::OUT_W-1] || (rsp_perp_b_x == '0) || rsp_perp_c_y[pbu_pkg::OUT_W-1] || (rsp_perp_c_y == '0), "norm component not negative")
   `PBU_ASSERT_NEXT(a_stall_hold, clock, reset, !req_ready, $stable(dly_valid_ff[pbu_pkg::UNIT_LAT-1]), "pipeline moved during stall")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int PIPE_LAT    = 58;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 530;

   typedef struct {
      logic signed [pbu_pkg::IN_W-1:0] x;
      logic signed [pbu_pkg::IN_W-1:0] y;
      logic signed [pbu_pkg::IN_W-1:0] z;
   } vec_type;

   typedef struct {
      logic                      ok;
      logic [pbu_pkg::OUT_W-1:0] bx, by, bz, cx, cy, cz;
   } basis_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [pbu_pkg::IN_W-1:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_valid_res;
   logic signed [pbu_pkg::OUT_W-1:0] rsp_perp_b_x, rsp_perp_b_y, rsp_perp_b_z;
   logic signed [pbu_pkg::OUT_W-1:0] rsp_perp_c_x, rsp_perp_c_y, rsp_perp_c_z;

   vec_type   pending_vecs[$];
   basis_type expected_bases[$];
   int        cycle_count = 0;
   int        mismatch_count = 0;
   bit        stim_done = 0;
   bit        hold_for_drain = 0;

   perpendicular_basis_unit u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 2^-16 rounded magnitude of sqrt(na*nb / (da*db)), ratio at most one
   function automatic logic [pbu_pkg::MAG_W-1:0] unit_root(logic [63:0] na, logic [63:0] nb,
                                                           logic [63:0] da, logic [63:0] db);
      logic [191:0] num, den;
      logic [63:0]  q, r, b, v;
      num = 192'(na) * 192'(nb);
      den = 192'(da) * 192'(db);
      if (den == 0) return '0;
      if (num >= den) return pbu_pkg::ONE_Q16;
      q = 64'((num << 34) / den);
      v = q; r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return pbu_pkg::MAG_W'((r + 1) >> 1);
   endfunction

   function automatic logic [pbu_pkg::OUT_W-1:0] signed_q(logic neg,
                                                          logic [pbu_pkg::MAG_W-1:0] m);
      logic [pbu_pkg::OUT_W-1:0] w;
      w = pbu_pkg::OUT_W'(m);
      return neg ? -w : w;
   endfunction

   function automatic basis_type predict_basis(vec_type v);
      basis_type   e;
      logic        nx, ny, nz;
      logic [63:0] ax, ay, az, x2, y2, z2, s, m2;
      nx = v.x[pbu_pkg::IN_W-1]; ny = v.y[pbu_pkg::IN_W-1]; nz = v.z[pbu_pkg::IN_W-1];
      ax = nx ? 64'(-64'(signed'(v.x))) : 64'(v.x);
      ay = ny ? 64'(-64'(signed'(v.y))) : 64'(v.y);
      az = nz ? 64'(-64'(signed'(v.z))) : 64'(v.z);
      e = '{1'b0, '0, '0, '0, '0, '0, '0};
      if (ax == 0 && ay == 0 && az == 0) return e;
      x2 = ax * ax; y2 = ay * ay; z2 = az * az;
      s = x2 + y2 + z2;
      e.ok = 1'b1;
      if (ax < ay) begin
         m2 = y2 + z2;
         e.bx = signed_q(1'b1, unit_root(m2, 1, s, 1));
         e.by = signed_q(nx != ny, unit_root(x2, y2, s, m2));
         e.bz = signed_q(nx != nz, unit_root(x2, z2, s, m2));
         e.cy = signed_q(nz, unit_root(z2, 1, m2, 1));
         e.cz = signed_q(!ny, unit_root(y2, 1, m2, 1));
      end else begin
         m2 = x2 + z2;
         e.bx = signed_q(!nz, unit_root(z2, 1, m2, 1));
         e.bz = signed_q(nx, unit_root(x2, 1, m2, 1));
         e.cx = signed_q(nx != ny, unit_root(x2, y2, s, m2));
         e.cy = signed_q(1'b1, unit_root(m2, 1, s, 1));
         e.cz = signed_q(ny != nz, unit_root(y2, z2, s, m2));
      end
      return e;
   endfunction

   function automatic logic signed [pbu_pkg::IN_W-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return pbu_pkg::IN_W'($urandom_range(0, 16)) - 24'sd8;
         1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         2: return pbu_pkg::IN_W'($urandom_range(0, 2000)) - 24'sd1000;
         default: return pbu_pkg::IN_W'($urandom);
      endcase
   endfunction

   task automatic add_vec(int x, int y, int z);
      pending_vecs.push_back('{pbu_pkg::IN_W'(x), pbu_pkg::IN_W'(y), pbu_pkg::IN_W'(z)});
   endtask

   initial begin
      vec_type v;
      add_vec(0, 0, 0);
      add_vec(1, 0, 0);
      add_vec(0, 1, 0);
      add_vec(0, 0, 1);
      add_vec(0, 0, -1);
      add_vec(-1, 0, 0);
      add_vec(0, -1, 0);
      add_vec(3, 3, 0);
      add_vec(-5, 5, 7);
      add_vec(2, -3, 4);
      add_vec(-3, 2, -4);
      add_vec(8388607, 8388607, 8388607);
      add_vec(-8388608, -8388608, -8388608);
      add_vec(-8388608, 8388607, 0);
      add_vec(8388607, -8388608, 1);
      add_vec(1, -8388608, -8388608);
      add_vec(-1, 1, -1);
      add_vec(0, 5, 0);
      add_vec(7, 0, -7);
      add_vec(12345, -6789, 4321);
      for (int i = 0; i < N_RANDOM; i++) begin
         v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
         if ($urandom_range(0, 9) == 0) v.x = $urandom_range(0, 1) ? v.y : -v.y;
         pending_vecs.push_back(v);
      end
   end

   // driver
   int req_wait = 0;
   int sent = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_bases.push_back(predict_basis('{req_vec_x, req_vec_y, req_vec_z}));
            sent++;
            req_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (sent == 270) hold_for_drain = 1;
         end
         if (hold_for_drain && expected_bases.size() == 0 && !(req_valid && req_ready))
            hold_for_drain = 0;
         if (req_valid && !req_ready) begin
            // hold until accepted
         end else if (pending_vecs.size() == 0) begin
            req_valid <= 1'b0;
            stim_done = 1;
         end else if (hold_for_drain || req_wait > 0) begin
            req_valid <= 1'b0;
            if (req_wait > 0) req_wait--;
         end else begin
            req_valid <= 1'b1;
            {req_vec_x, req_vec_y, req_vec_z} <= {pending_vecs[0].x, pending_vecs[0].y,
                                                  pending_vecs[0].z};
            void'(pending_vecs.pop_front());
         end
      end
   end

   // monitor
   int rsp_wait = 0;
   always @(posedge clock) begin
      basis_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bases.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected transaction at cycle %0d",
                                                  cycle_count);
            end else begin
               e = expected_bases.pop_front();
               if (e.ok !== rsp_valid_res || e.bx !== rsp_perp_b_x ||
                   e.by !== rsp_perp_b_y || e.bz !== rsp_perp_b_z ||
                   e.cx !== rsp_perp_c_x || e.cy !== rsp_perp_c_y ||
                   e.cz !== rsp_perp_c_z) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp %0b b(%0d %0d %0d) c(%0d %0d %0d)",
                               " got %0b b(%0d %0d %0d) c(%0d %0d %0d)"},
                        e.ok, signed'(e.bx), signed'(e.by), signed'(e.bz),
                        signed'(e.cx), signed'(e.cy), signed'(e.cz), rsp_valid_res,
                        rsp_perp_b_x, rsp_perp_b_y, rsp_perp_b_z,
                        rsp_perp_c_x, rsp_perp_c_y, rsp_perp_c_z);
               end
            end
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && expected_bases.size() == 0);
            repeat (PIPE_LAT * 2) @(posedge clock);
         end
         begin
            while (cycle_count < CYCLE_LIMIT) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("perpendicular_basis_unit regression: fail");
            $finish;
         end
      join_any
      if (mismatch_count == 0)
         $display("perpendicular_basis_unit regression: pass");
      else
         $display("perpendicular_basis_unit regression: fail");
      $finish;
   end

endmodule
